@@ src/fbc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants for the frustum box cull block.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int COEF_BITS   = 16;
  localparam int COORD_BITS  = 16;
  localparam int ROW_COUNT   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  // constant term lines up with coef*coord products (4 fraction bits)
  localparam int CONST_SHIFT = 4;

  localparam int PCOEF_BITS  = COEF_BITS + 1;
  localparam int PROD_BITS   = PCOEF_BITS + COORD_BITS;
  localparam int ACC_BITS    = PROD_BITS + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2,
    REG_ROW_W = 2'd3
  } cfg_reg_e;

  typedef logic [CFG_DATA_W-1:0]        cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic signed [PCOEF_BITS-1:0] pcoef_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;

  typedef struct packed {
    pcoef_t w;
    pcoef_t z;
    pcoef_t y;
    pcoef_t x;
  } plane_t;

  typedef plane_t [PLANE_COUNT-1:0] plane_set_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  function automatic coef_t row_coef(input cfg_data_t row, input int unsigned idx);
    return coef_t'(row[idx*COEF_BITS +: COEF_BITS]);
  endfunction

endpackage

@@ src/frustum_box_cull.sv @@
// ----------------------------------------------------------------------------
// frustum_box_cull
// View-frustum test of axis-aligned boxes against six planes taken from a
// view-projection matrix.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir | notes
//  --------+------------------------------------------+-----+----------------
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i         | in  | matrix rows
//  box     | in_valid_i/in_ready_o, box_min_*, box_max_* | in | one box
//  result  | out_valid_o/out_ready_i, visible_o       | out | one bit per box
//
//  One box per cycle while results are taken; each box passes through the input
//  register, product register and result register.
//  Each stage advances when the stage after it is empty or advancing, so a
//  stalled result only blocks once all three stages hold a box.
//  Reset clears the matrix to zero: every box then reads as visible.
// ----------------------------------------------------------------------------
module frustum_box_cull (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  fbc_pkg::cfg_idx_t  cfg_idx_i,
  input  fbc_pkg::cfg_data_t cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fbc_pkg::coord_t    box_min_x_i,
  input  fbc_pkg::coord_t    box_min_y_i,
  input  fbc_pkg::coord_t    box_min_z_i,
  input  fbc_pkg::coord_t    box_max_x_i,
  input  fbc_pkg::coord_t    box_max_y_i,
  input  fbc_pkg::coord_t    box_max_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               visible_o
);
  import fbc_pkg::*;

  plane_set_t             planes;
  box_t                   box_q;
  logic                   v0_q, v1_q, v2_q;
  logic                   en0, en1, en2;
  logic [PLANE_COUNT-1:0] plane_ok;
  logic                   visible_q;

  fbc_plane_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .planes_o    (planes)
  );

  assign en2 = !v2_q || out_ready_i;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_ready_o = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      box_q <= '{min_x: box_min_x_i, min_y: box_min_y_i, min_z: box_min_z_i,
                 max_x: box_max_x_i, max_y: box_max_y_i, max_z: box_max_z_i};
    end
    if (en2) begin
      visible_q <= &plane_ok;
    end
  end

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    fbc_plane_eval u_eval (
      .clk_i    (clk_i),
      .en_i     (en1),
      .plane_i  (planes[p]),
      .box_i    (box_q),
      .inside_o (plane_ok[p])
    );
  end

  assign out_valid_o = v2_q;
  assign visible_o   = visible_q;

  // a transfer always lands in the input stage
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v0_q)
    else $error("accepted box not held in input stage");

  // input only backs up when the whole pipe is full and the sink stalls
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v0_q && v1_q && v2_q && !out_ready_i))
    else $error("input stalled with room in the pipe");

  // a held product stage keeps its box
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> v1_q)
    else $error("product stage dropped a box");

  // results are never repeated: an output that advances with no box behind it empties
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && out_ready_i && !v1_q) |=> !v2_q)
    else $error("result repeated");

endmodule

@@ src/fbc_plane_regs.sv @@
// ----------------------------------------------------------------------------
// fbc_plane_regs
// Matrix row registers and the six clip planes derived from them.
// ----------------------------------------------------------------------------
module fbc_plane_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  fbc_pkg::cfg_idx_t     cfg_idx_i,
  input  fbc_pkg::cfg_data_t    cfg_wdata_i,
  output fbc_pkg::plane_set_t   planes_o
);
  import fbc_pkg::*;

  cfg_data_t  row_q [ROW_COUNT];
  cfg_data_t  row_d [ROW_COUNT];
  plane_set_t planes_q, planes_d;

  always_comb begin
    for (int r = 0; r < ROW_COUNT; r++) begin
      row_d[r] = row_q[r];
    end
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROW_X: row_d[0] = cfg_wdata_i;
        REG_ROW_Y: row_d[1] = cfg_wdata_i;
        REG_ROW_Z: row_d[2] = cfg_wdata_i;
        REG_ROW_W: row_d[3] = cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // planes computed from the next row values so they track writes directly
  always_comb begin
    pcoef_t cx, cy, cz, cw;
    for (int k = 0; k < ROW_COUNT; k++) begin
      cx = pcoef_t'(row_coef(row_d[0], k));
      cy = pcoef_t'(row_coef(row_d[1], k));
      cz = pcoef_t'(row_coef(row_d[2], k));
      cw = pcoef_t'(row_coef(row_d[3], k));
      planes_d[0][k*PCOEF_BITS +: PCOEF_BITS] = cw + cx;
      planes_d[1][k*PCOEF_BITS +: PCOEF_BITS] = cw - cx;
      planes_d[2][k*PCOEF_BITS +: PCOEF_BITS] = cw + cy;
      planes_d[3][k*PCOEF_BITS +: PCOEF_BITS] = cw - cy;
      planes_d[4][k*PCOEF_BITS +: PCOEF_BITS] = cw + cz;
      planes_d[5][k*PCOEF_BITS +: PCOEF_BITS] = -cz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        row_q[r] <= '0;
      end
      planes_q <= '0;
    end else begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        row_q[r] <= row_d[r];
      end
      planes_q <= planes_d;
    end
  end

  assign planes_o = planes_q;

endmodule

@@ src/fbc_plane_eval.sv @@
// ----------------------------------------------------------------------------
// fbc_plane_eval
// One clip plane: picks the far corner, registers the three products and
// reports whether the plane value at that corner is non-negative.
// ----------------------------------------------------------------------------
module fbc_plane_eval (
  input  logic            clk_i,
  input  logic            en_i,
  input  fbc_pkg::plane_t plane_i,
  input  fbc_pkg::box_t   box_i,
  output logic            inside_o
);
  import fbc_pkg::*;

  coord_t px, py, pz;
  prod_t  prod_x_q, prod_y_q, prod_z_q;
  acc_t   acc;

  // zero coefficient counts as non-negative and takes the max corner
  assign px = plane_i.x[PCOEF_BITS-1] ? box_i.min_x : box_i.max_x;
  assign py = plane_i.y[PCOEF_BITS-1] ? box_i.min_y : box_i.max_y;
  assign pz = plane_i.z[PCOEF_BITS-1] ? box_i.min_z : box_i.max_z;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= prod_t'(plane_i.x) * prod_t'(px);
      prod_y_q <= prod_t'(plane_i.y) * prod_t'(py);
      prod_z_q <= prod_t'(plane_i.z) * prod_t'(pz);
    end
  end

  // the user must change the plane set only while idle (the block does not enforce this), so w is read live here
  assign acc = acc_t'(prod_x_q) + acc_t'(prod_y_q) + acc_t'(prod_z_q)
             + (acc_t'(plane_i.w) <<< CONST_SHIFT);

  assign inside_o = ~acc[ACC_BITS-1];

endmodule
